// ===== rtl/fce_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the front coding encoder.
// No dependencies.
package fce_pkg;

  localparam int CHAR_W = 8;
  localparam int COUNT_W = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // queue between classifier and encoder
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CHAR_W-1:0] key_char;
    logic              has_char;
    logic              key_last;
    logic              block_start;
  } key_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  out_char;
    logic               out_has_char;
    logic [COUNT_W-1:0] prefix_count;
    logic               count_present;
    logic               key_end;
    logic               too_long;
  } code_item_t;

  // CMD_CHAR: a character, CMD_END: key ends with no character,
  // CMD_SYNC: block start carried on an otherwise empty beat
  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_END,
    CMD_SYNC
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              bstart;
  } cmd_t;

endpackage

// ===== rtl/fce_front.sv =====
`timescale 1ns / 1ps
// Input stage: registers incoming beats, classifies them and drops empty ones.
// Depends on fce_pkg.
module fce_front import fce_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      key_valid,
  output logic      key_stall,
  input  key_item_t key_item,
  output logic      push,
  output cmd_t      push_cmd,
  input  logic      queue_full
);

  logic held;
  cmd_t cmd;
  cmd_t cmd_next;
  logic keep;

  assign key_stall = held && queue_full;
  assign push      = held && !queue_full;
  assign push_cmd  = cmd;

  always_comb begin
    cmd_next.ch     = key_item.key_char;
    cmd_next.last   = key_item.key_last;
    cmd_next.bstart = key_item.block_start;
    keep            = 1'b1;
    if (key_item.has_char) begin
      cmd_next.kind = CMD_CHAR;
    end else if (key_item.key_last) begin
      cmd_next.kind = CMD_END;
    end else begin
      cmd_next.kind = CMD_SYNC;
      keep          = key_item.block_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!key_stall) begin
      held <= key_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!key_stall && key_valid) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== rtl/fce_queue.sv =====
`timescale 1ns / 1ps
// Small command queue between classifier and encoder.
// Depends on fce_pkg.
module fce_queue import fce_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t head
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full     = (fill == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (fill != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/fce_back.sv =====
`timescale 1ns / 1ps
// Encoder: previous-key store, prefix matching and the output register.
// Depends on fce_pkg.
module fce_back import fce_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       nonempty,
  input  cmd_t       head,
  output logic       pop,
  output logic       code_valid,
  input  logic       code_stall,
  output code_item_t code_item
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);

  logic [CHAR_W-1:0] prev_key [MAX_LEN];
  logic [CHAR_W-1:0] rd_data;

  logic [PW-1:0] prev_len;
  logic [PW-1:0] position;
  logic          still_matching;
  logic          first_of_block;
  logic          overflowed;

  logic [PW-1:0] prev_len_next;
  logic [PW-1:0] position_next;
  logic          still_matching_next;
  logic          first_of_block_next;
  logic          overflowed_next;

  logic [PW-1:0] pos_cur;
  logic          sm_cur;
  logic          fob_cur;
  logic          ovf_cur;
  logic          matching;
  logic          hit;
  logic          emit;
  logic          finish;
  logic [PW-1:0] count;
  logic          res_has;
  logic          res_end;
  logic          res_long;
  logic [COUNT_W-1:0] sat_count;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          out_free;

  assign out_free = !code_valid || !code_stall;
  assign pop      = nonempty && out_free;

  always_comb begin
    pos_cur  = head.bstart ? '0 : position;
    sm_cur   = head.bstart ? 1'b1 : still_matching;
    fob_cur  = head.bstart ? 1'b1 : first_of_block;
    ovf_cur  = head.bstart ? 1'b0 : overflowed;
    matching = sm_cur && !fob_cur;
    // rd_data holds the stored character at the current position
    hit = matching && (pos_cur < prev_len) && (pos_cur < PW'(MAX_LEN))
          && (rd_data == head.ch);

    prev_len_next       = prev_len;
    position_next       = pos_cur;
    still_matching_next = sm_cur;
    first_of_block_next = fob_cur;
    overflowed_next     = ovf_cur;
    emit     = 1'b0;
    finish   = 1'b0;
    count    = '0;
    res_has  = 1'b0;
    res_end  = 1'b0;
    res_long = ovf_cur;
    wr_en    = 1'b0;
    wr_addr  = pos_cur[AW-1:0];

    case (head.kind)
      CMD_CHAR: begin
        if (hit) begin
          position_next = pos_cur + 1'b1;
          if (head.last) begin
            emit    = 1'b1;
            finish  = 1'b1;
            count   = pos_cur + 1'b1;
            res_end = 1'b1;
          end
        end else begin
          count = matching ? pos_cur : '0;
          if (pos_cur < PW'(MAX_LEN)) begin
            wr_en         = 1'b1;
            position_next = pos_cur + 1'b1;
          end else begin
            overflowed_next = 1'b1;
          end
          still_matching_next = 1'b0;
          emit     = 1'b1;
          res_has  = 1'b1;
          res_end  = head.last;
          res_long = overflowed_next;
          finish   = head.last;
        end
      end
      CMD_END: begin
        emit    = 1'b1;
        finish  = 1'b1;
        count   = matching ? pos_cur : '0;
        res_end = 1'b1;
      end
      default: begin
        // block start with nothing else: state reset only
      end
    endcase

    if (finish) begin
      prev_len_next       = position_next;
      position_next       = '0;
      still_matching_next = 1'b1;
      first_of_block_next = 1'b0;
      overflowed_next     = 1'b0;
    end

    sat_count = (32'(count) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(count);

    // prefetch the stored character for the next beat
    if (!pop || position_next >= PW'(MAX_LEN)) begin
      rd_addr = (position >= PW'(MAX_LEN)) ? '0 : position[AW-1:0];
    end else begin
      rd_addr = position_next[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && wr_en) begin
      prev_key[wr_addr] <= head.ch;
    end
    if (pop && wr_en && wr_addr == rd_addr) begin
      rd_data <= head.ch;
    end else begin
      rd_data <= prev_key[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_len       <= '0;
      position       <= '0;
      still_matching <= 1'b1;
      first_of_block <= 1'b1;
      overflowed     <= 1'b0;
      code_valid     <= 1'b0;
    end else begin
      if (pop) begin
        prev_len       <= prev_len_next;
        position       <= position_next;
        still_matching <= still_matching_next;
        first_of_block <= first_of_block_next;
        overflowed     <= overflowed_next;
      end
      if (out_free) begin
        code_valid <= pop && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      code_item.out_char      <= res_has ? head.ch : '0;
      code_item.out_has_char  <= res_has;
      code_item.prefix_count  <= sat_count;
      code_item.count_present <= (sat_count != '0);
      code_item.key_end       <= res_end;
      code_item.too_long      <= res_long;
    end
  end

endmodule

// ===== rtl/front_coding_encoder.sv =====
`timescale 1ns / 1ps
// Front coding encoder for sorted keys, one character per beat.
// Depends on fce_pkg, fce_front, fce_queue and fce_back.
//
// Input channel key_valid / key_stall / key_item: one character of the
// current key per beat, with key_last on the final beat and block_start on
// the first beat of a block. Output channel code_valid / code_stall /
// code_item: zero or one result per input beat. Matching leading
// characters give nothing; the first differing character carries the
// shared-prefix count, later characters follow plainly.
// A result on code_item has passed the input register, the queue and the
// output register. Throughput: one beat per cycle while code_stall is low,
// set by the encoder's single previous-key read and write per beat;
// the read for the next position is fetched while the current beat is
// encoded.
// Reset clears the counters, so the next key passes through whole with a
// count of zero; the previous-key store is not cleared, and needs no pass.
// When code_stall is high the output register holds, the four-entry queue
// fills, and key_stall rises once the queue and input register are full.
module front_coding_encoder import fce_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       key_valid,
  output logic       key_stall,
  input  key_item_t  key_item,
  output logic       code_valid,
  input  logic       code_stall,
  output code_item_t code_item
);

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic pop;
  logic nonempty;
  cmd_t head;

  fce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .key_valid  (key_valid),
    .key_stall  (key_stall),
    .key_item   (key_item),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  fce_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  fce_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .nonempty   (nonempty),
    .head       (head),
    .pop        (pop),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_item  (code_item)
  );

endmodule

// ===== test/tb_front_coding_encoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for front_coding_encoder: directed keys, then random
// key sequences under four handshake phases. Depends on fce_pkg and the RTL.
module tb_front_coding_encoder;
  import fce_pkg::*;

  localparam int KEY_MAX = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BEATS = 500;
  localparam int GAP_PCT [4] = '{0, 87, 0, 34};
  localparam int STALL_PCT [4] = '{0, 0, 87, 34};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       key_valid = 1'b0;
  logic       key_stall;
  key_item_t  key_item = '0;
  logic       code_valid;
  logic       code_stall = 1'b0;
  code_item_t code_item;

  front_coding_encoder #(.MAX_LEN(KEY_MAX)) dut (
    .clk(clk),
    .rst(rst),
    .key_valid(key_valid),
    .key_stall(key_stall),
    .key_item(key_item),
    .code_valid(code_valid),
    .code_stall(code_stall),
    .code_item(code_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  key_item_t    pending_beats[$];
  code_item_t   expected_codes[$];
  byte unsigned last_key[$];
  int unsigned  beats_queued = 0, beats_taken = 0, counted_beats = 0;
  int unsigned  codes_seen = 0, long_codes = 0, errors = 0, cycle_count = 0;
  int           send_gap_pct = 0, recv_stall_pct = 0;
  logic         key_fire = 1'b0;

  // Predictor state: previous key, its length, and progress through the current key
  logic [7:0]   stored_key [KEY_MAX];
  int unsigned  stored_len = 0, pos = 0;
  bit           matching_run = 1'b1, block_first = 1'b1, overflow_seen = 1'b0;

  function automatic code_item_t make_code(input logic [7:0] ch, input bit has,
                                           input int unsigned cnt, input bit fin);
    code_item_t c;
    int unsigned sat;
    sat = (cnt > COUNT_MAX) ? COUNT_MAX : cnt;
    c.out_char = has ? ch : 8'h00;
    c.out_has_char = has;
    c.prefix_count = sat[COUNT_W-1:0];
    c.count_present = (sat != 0);
    c.key_end = fin;
    c.too_long = overflow_seen;
    return c;
  endfunction

  function automatic void close_key();
    stored_len = pos;
    pos = 0;
    matching_run = 1'b1;
    block_first = 1'b0;
    overflow_seen = 1'b0;
  endfunction

  // Returns 1 when the beat yields a code; the code goes out through res.
  function automatic bit encode_beat(input key_item_t it, output code_item_t res);
    bit cmp;
    int unsigned cnt;
    res = '0;
    if (it.block_start) begin
      block_first = 1'b1;
      pos = 0;
      matching_run = 1'b1;
      overflow_seen = 1'b0;
    end
    cmp = matching_run && !block_first;
    if (!it.has_char) begin
      if (!it.key_last) return 1'b0;
      res = make_code(8'h00, 1'b0, cmp ? pos : 0, 1'b1);
      close_key();
      return 1'b1;
    end
    if (cmp && pos < stored_len && pos < KEY_MAX && stored_key[pos] == it.key_char) begin
      pos++;
      if (it.key_last) begin
        res = make_code(8'h00, 1'b0, pos, 1'b1);
        close_key();
        return 1'b1;
      end
      return 1'b0;
    end
    // mismatch or ran past the previous key: count goes out with this char
    cnt = cmp ? pos : 0;
    if (pos < KEY_MAX) begin
      stored_key[pos] = it.key_char;
      pos++;
    end else begin
      overflow_seen = 1'b1;
    end
    matching_run = 1'b0;
    res = make_code(it.key_char, 1'b1, cnt, it.key_last);
    if (it.key_last) close_key();
    return 1'b1;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      errors++;
    end
  endtask

  // Driver: inputs move on the falling edge only
  always @(negedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
      code_stall <= 1'b0;
    end else begin
      code_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!key_valid || key_fire) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          key_item <= pending_beats[0];
          pending_beats.delete(0);
          key_valid <= 1'b1;
        end else begin
          key_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on accepted key beats, check accepted code beats
  always @(posedge clk) begin : monitor
    code_item_t made;
    code_item_t want;
    cycle_count++;
    if (rst) begin
      key_fire <= 1'b0;
    end else begin
      key_fire <= key_valid && !key_stall;
      if (key_valid && !key_stall) begin
        beats_taken++;
        if (encode_beat(key_item, made)) expected_codes.push_back(made);
      end
      if (code_valid && !code_stall) begin
        codes_seen++;
        if (code_item.too_long === 1'b1) long_codes++;
        if (expected_codes.size() == 0) begin
          $error("code beat with nothing expected: %p", code_item);
          errors++;
        end else begin
          want = expected_codes[0];
          expected_codes.delete(0);
          check_field("out_char", want.out_char, code_item.out_char);
          check_field("out_has_char", want.out_has_char, code_item.out_has_char);
          check_field("prefix_count", want.prefix_count, code_item.prefix_count);
          check_field("count_present", want.count_present, code_item.count_present);
          check_field("key_end", want.key_end, code_item.key_end);
          check_field("too_long", want.too_long, code_item.too_long);
        end
      end
    end
  end

  function automatic byte unsigned pick_char();
    // narrow alphabet most of the time so prefixes actually match
    if ($urandom_range(3) != 0) return 8'(8'h61 + $urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  task automatic queue_beat(input logic [7:0] ch, input bit has, input bit last,
                            input bit bs);
    key_item_t it;
    it.key_char = ch;
    it.has_char = has;
    it.key_last = last;
    it.block_start = bs;
    pending_beats.push_back(it);
    beats_queued++;
    if (has || last) counted_beats++;
  endtask

  task automatic queue_key(input byte unsigned chars[$], input bit bs,
                           input bit split_end);
    int n;
    n = chars.size();
    if (n == 0) begin
      queue_beat(8'($urandom_range(255)), 1'b0, 1'b1, bs);
    end else begin
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 5) queue_beat(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
        queue_beat(chars[i], 1'b1, (i == n - 1) && !split_end, bs && (i == 0));
      end
      if (split_end) queue_beat(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0);
    end
    last_key = chars;
  endtask

  // New key built from a random prefix of the last one
  task automatic queue_random_key();
    byte unsigned chars[$];
    int keep, kind, len_goal;
    bit bs;
    kind = $urandom_range(99);
    keep = $urandom_range(last_key.size());
    bs = ($urandom_range(19) == 0);
    if ($urandom_range(24) == 0) begin
      // partial key abandoned by a block start
      for (int i = 0; i < 1 + $urandom_range(2); i++)
        queue_beat(pick_char(), 1'b1, 1'b0, 1'b0);
      bs = 1'b1;
    end
    if (kind < 4) begin
      if ($urandom_range(1) == 1) keep = last_key.size();
      len_goal = $urandom_range(KEY_MAX - 4, KEY_MAX + 8);
    end else if (kind < 16) begin
      len_goal = keep;
    end else begin
      len_goal = keep + $urandom_range(1, 6);
    end
    for (int i = 0; i < keep; i++) chars.push_back(last_key[i]);
    while (chars.size() < len_goal) chars.push_back(pick_char());
    queue_key(chars, bs, $urandom_range(9) == 0);
  endtask

  task automatic wait_until_drained();
    while (beats_taken != beats_queued || expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int target;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 4; p++) begin
      send_gap_pct = GAP_PCT[p];
      recv_stall_pct = STALL_PCT[p];
      if (p == 0) begin
        // first key of a block goes through whole
        queue_beat(8'h61, 1'b1, 1'b0, 1'b1);
        queue_beat(8'h62, 1'b1, 1'b1, 1'b0);
        // same key again: ends while still matching
        queue_beat(8'h61, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h62, 1'b1, 1'b1, 1'b0);
        // runs past the previous key
        queue_beat(8'h61, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h62, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h63, 1'b1, 1'b1, 1'b0);
        // mismatch, then closed by a beat with no character
        queue_beat(8'h61, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h78, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b1, 1'b0);
        // empty key, then an idle beat
        queue_beat(8'hFF, 1'b0, 1'b1, 1'b0);
        queue_beat(8'hA5, 1'b0, 1'b0, 1'b0);
        // character extremes
        queue_beat(8'h00, 1'b1, 1'b0, 1'b0);
        queue_beat(8'hFF, 1'b1, 1'b1, 1'b0);
        // block start in the middle of a key
        queue_beat(8'h00, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h61, 1'b1, 1'b1, 1'b1);
        // block start on an idle beat
        queue_beat(8'h5A, 1'b0, 1'b0, 1'b1);
        queue_beat(8'h61, 1'b1, 1'b1, 1'b0);
        last_key = '{8'h61};
        wait_until_drained();
      end
      target = counted_beats + PHASE_BEATS;
      while (counted_beats < target) queue_random_key();
      // sender holds off here until every code is back
      wait_until_drained();
    end
    $display("Sent %0d key beats over four handshake phases, checked %0d codes",
             beats_taken, codes_seen);
    $display("%0d codes carried the over-length flag", long_codes);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
